FILE: design/imd_pkg.sv
// shared types and constants for the integer matrix determinant block
`default_nettype none

package imd_pkg;

  localparam int unsigned DET_BITS = 64;
  localparam int unsigned CFG_BITS = 4;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN
  } imd_state_e;

  // tag that follows one cofactor term down the multiply-accumulate pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic negate;
    logic final_term;
    logic m_one;
  } term_ctl_t;

  typedef struct packed {
    logic                wr_en;
    logic                done;
    logic [DET_BITS-1:0] value;
  } mac_res_t;

endpackage

`default_nettype wire

FILE: design/imd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module imd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/imd_mac.sv
// pipelined cofactor term multiply and signed accumulate with minor write-back
`default_nettype none

module imd_mac #(
  parameter int unsigned SET_BITS     = 8,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire imd_pkg::term_ctl_t             ctl_i,
  input  wire logic [SET_BITS-1:0]            set_i,
  input  wire logic [ELEMENT_BITS-1:0]        elem_i,
  input  wire logic [imd_pkg::DET_BITS-1:0]   minor_i,
  input  wire logic                           out_busy_i,
  input  wire logic [SET_BITS-1:0]            probe_i,
  output logic                                probe_hit_o,
  output logic [SET_BITS-1:0]                 wr_addr_o,
  output imd_pkg::mac_res_t                   res_o
);

  localparam int unsigned HALF = imd_pkg::DET_BITS / 2;
  localparam int unsigned OPW  = HALF + 1;

  imd_pkg::term_ctl_t ctl2_q, ctl3_q;
  logic [SET_BITS-1:0] set2_q, set3_q;
  logic [imd_pkg::DET_BITS-1:0] lo2_q, term3_q, acc_q, acc_d, acc_base;
  logic [ELEMENT_BITS-1:0] e2_q;
  logic [HALF-1:0] mh2_q;

  logic signed [OPW-1:0] e_ext, ml_ext, e2_ext, mh_ext;
  logic signed [2*OPW-1:0] prod_lo, prod_hi;
  logic hold, advance;

  // signed element times unsigned halves of the minor, modulo 2^64
  assign e_ext   = {{(OPW-ELEMENT_BITS){elem_i[ELEMENT_BITS-1]}}, elem_i};
  assign ml_ext  = {1'b0, minor_i[HALF-1:0]};
  assign prod_lo = e_ext * ml_ext;
  assign e2_ext  = {{(OPW-ELEMENT_BITS){e2_q[ELEMENT_BITS-1]}}, e2_q};
  assign mh_ext  = {1'b0, mh2_q};
  assign prod_hi = e2_ext * mh_ext;

  // final result waits in the last stage while the output register is full
  assign hold    = ctl3_q.valid && ctl3_q.final_term && out_busy_i;
  assign advance = ctl3_q.valid && !hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl2_q <= ctl_i;
      if (!hold) begin
        ctl3_q <= ctl2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo2_q  <= prod_lo[imd_pkg::DET_BITS-1:0];
    e2_q   <= elem_i;
    mh2_q  <= minor_i[imd_pkg::DET_BITS-1:HALF];
    set2_q <= set_i;
    if (!hold) begin
      term3_q <= {lo2_q[imd_pkg::DET_BITS-1:HALF] + prod_hi[HALF-1:0], lo2_q[HALF-1:0]};
      set3_q  <= set2_q;
    end
    if (advance) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    acc_base = ctl3_q.first ? '0 : acc_q;
    acc_d    = ctl3_q.negate ? (acc_base - term3_q) : (acc_base + term3_q);
  end

  assign res_o.wr_en = advance && ctl3_q.last;
  assign res_o.done  = advance && ctl3_q.final_term;
  assign res_o.value = acc_d;
  assign wr_addr_o   = set3_q;

  // minors still in flight here are not yet in memory
  assign probe_hit_o = (ctl2_q.valid && (set2_q == probe_i)) ||
                       (ctl3_q.valid && (set3_q == probe_i));

endmodule

`default_nettype wire

FILE: design/integer_matrix_determinant.sv
// Integer matrix determinant by cofactor expansion over column subsets.
// Configuration: cfg_we_i writes cfg_wdata_i as the matrix size n; 0 reads as 1,
// values above MAX_SIZE saturate, and every write restarts loading.
// Input channel: one signed element per transfer, row-major, n*n transfers
// per matrix; one transfer per cycle while loading (in_stall_o low).
// Output channel: one 64-bit wrapped determinant per matrix.
// After the last element, in_stall_o stays high while the minors are built:
// every nonempty column subset gets one minor, one cofactor term per cycle
// from the element and minor memories, except that issue waits while a term
// needs a minor that is still in the multiply-accumulate pipe and not yet in
// memory. The final term then runs through that pipe into the output register.
// The result sits in an output register; out_stall_i holds it there, and a
// following matrix can load meanwhile; its final term waits for the register.
// Reset: size 1, empty load count, no result pending; memories are not cleared.
`default_nettype none

module integer_matrix_determinant #(
  parameter int unsigned MAX_SIZE     = 8,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [imd_pkg::CFG_BITS-1:0]         cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [ELEMENT_BITS-1:0]       element_value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [imd_pkg::DET_BITS-1:0]       determinant_o
);

  localparam int unsigned CFGW = imd_pkg::CFG_BITS;
  localparam int unsigned SZW  = $clog2(MAX_SIZE + 1);
  localparam int unsigned JW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned NE   = MAX_SIZE * MAX_SIZE;
  localparam int unsigned EAW  = (NE > 1) ? $clog2(NE) : 1;
  localparam int unsigned CNTW = $clog2(NE + 1);
  localparam int unsigned SB   = MAX_SIZE;
  localparam int unsigned ND   = 1 << MAX_SIZE;

  imd_pkg::imd_state_e state_q, state_d;
  logic [SZW-1:0]  n_q, n_cfg;
  logic [CNTW-1:0] total_q, load_cnt_q, load_cnt_d, cnt_inc;
  logic [2*SZW-1:0] n_sq;
  logic [SB-1:0]   set_q, set_d, rem_q, rem_d, set1_q;
  imd_pkg::term_ctl_t ctl1_q, ctl1_d;

  logic [SB-1:0]   full_mask, jmask, below, ma, rem_next;
  logic [JW-1:0]   j;
  logic [SZW-1:0]  pc, row;
  logic [2*SZW-1:0] row_base, e_sum;
  logic [EAW-1:0]  e_addr;
  logic            last, parity, hit, mac_hit;

  logic [ELEMENT_BITS-1:0]       e_rd;
  logic [imd_pkg::DET_BITS-1:0]  m_rd, m_data;
  logic [SB-1:0]                 m_waddr;
  imd_pkg::mac_res_t             mac_res;

  logic                          out_valid_q;
  logic [imd_pkg::DET_BITS-1:0]  det_q;

  // size register and its square
  always_comb begin
    if (cfg_wdata_i == '0) begin
      n_cfg = SZW'(1);
    end else if (cfg_wdata_i > CFGW'(MAX_SIZE)) begin
      n_cfg = SZW'(MAX_SIZE);
    end else begin
      n_cfg = SZW'(cfg_wdata_i);
    end
    n_sq = n_cfg * n_cfg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= SZW'(1);
      total_q <= CNTW'(1);
    end else if (cfg_we_i) begin
      n_q     <= n_cfg;
      total_q <= CNTW'(n_sq);
    end
  end

  // term selection: highest remaining column of the current subset
  always_comb begin
    j  = '0;
    pc = '0;
    for (int b = 0; b < SB; b++) begin
      if (rem_q[b]) begin
        j = JW'(b);
      end
      pc = pc + SZW'(set_q[b]);
    end
    for (int b = 0; b < SB; b++) begin
      jmask[b]     = (JW'(b) == j);
      below[b]     = (JW'(b) < j);
      full_mask[b] = (SZW'(b) < n_q);
    end
    ma       = set_q & ~jmask;
    rem_next = rem_q & ~jmask;
    last     = (rem_next == '0);
    parity   = ^(set_q & below);
    // minor over k columns uses the bottom k rows
    row      = n_q - pc;
    row_base = row * n_q;
    e_sum    = row_base + {{(2*SZW-JW){1'b0}}, j};
    e_addr   = EAW'(e_sum);
    hit      = (ctl1_q.valid && (set1_q == ma)) || mac_hit;
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    set_d      = set_q;
    rem_d      = rem_q;
    ctl1_d     = '0;
    cnt_inc    = load_cnt_q + CNTW'(1);
    in_stall_o = (state_q != imd_pkg::ST_LOAD);
    case (state_q)
      imd_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          if (cnt_inc == total_q) begin
            load_cnt_d = '0;
            set_d      = SB'(1);
            rem_d      = SB'(1);
            state_d    = imd_pkg::ST_ISSUE;
          end else begin
            load_cnt_d = cnt_inc;
          end
        end
      end
      imd_pkg::ST_ISSUE: begin
        if (!hit) begin
          ctl1_d.valid      = 1'b1;
          ctl1_d.first      = (rem_q == set_q);
          ctl1_d.last       = last;
          ctl1_d.negate     = parity;
          ctl1_d.final_term = last && (set_q == full_mask);
          ctl1_d.m_one      = (ma == '0);
          if (last) begin
            if (set_q == full_mask) begin
              state_d = imd_pkg::ST_DRAIN;
            end else begin
              set_d = set_q + SB'(1);
              rem_d = set_q + SB'(1);
            end
          end else begin
            rem_d = rem_next;
          end
        end
      end
      imd_pkg::ST_DRAIN: begin
        if (mac_res.done) begin
          state_d = imd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = imd_pkg::ST_LOAD;
      end
    endcase
    if (cfg_we_i) begin
      load_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= imd_pkg::ST_LOAD;
      load_cnt_q <= '0;
      set_q      <= '0;
      rem_q      <= '0;
      ctl1_q     <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      set_q      <= set_d;
      rem_q      <= rem_d;
      ctl1_q     <= ctl1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set1_q <= set_q;
  end

  imd_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (NE)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == imd_pkg::ST_LOAD) && in_valid_i),
    .waddr_i (load_cnt_q[EAW-1:0]),
    .wdata_i (element_value_i),
    .raddr_i (e_addr),
    .rdata_o (e_rd)
  );

  imd_ram #(
    .WIDTH (imd_pkg::DET_BITS),
    .DEPTH (ND)
  ) u_minor_ram (
    .clk_i   (clk_i),
    .we_i    (mac_res.wr_en),
    .waddr_i (m_waddr),
    .wdata_i (mac_res.value),
    .raddr_i (ma),
    .rdata_o (m_rd)
  );

  // the empty minor is one and never lives in memory
  assign m_data = ctl1_q.m_one ? imd_pkg::DET_BITS'(1) : m_rd;

  imd_mac #(
    .SET_BITS     (SB),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl1_q),
    .set_i       (set1_q),
    .elem_i      (e_rd),
    .minor_i     (m_data),
    .out_busy_i  (out_valid_q && out_stall_i),
    .probe_i     (ma),
    .probe_hit_o (mac_hit),
    .wr_addr_o   (m_waddr),
    .res_o       (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mac_res.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_res.done) begin
      det_q <= mac_res.value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign determinant_o = det_q;

endmodule

`default_nettype wire

FILE: sim/det_check_pkg.sv
// determinant predictor and result scoreboard for the matrix determinant testbench
`timescale 1ns / 1ps

package det_check_pkg;

  localparam int unsigned MAX_SIDE = 8;

  class det_scoreboard;
    logic [3:0]                   size_code;
    int unsigned                  loaded;
    logic [imd_pkg::DET_BITS-1:0] entries [MAX_SIDE*MAX_SIDE];
    logic [imd_pkg::DET_BITS-1:0] expected_dets [$];
    int unsigned                  mismatches;

    function new();
      size_code  = 4'd1;
      loaded     = 0;
      mismatches = 0;
    endfunction

    // zero reads as one, anything above the largest side saturates
    function int unsigned active_side();
      if (size_code == 4'd0) return 1;
      if (size_code > MAX_SIDE) return MAX_SIDE;
      return size_code;
    endfunction

    function int unsigned pending();
      return expected_dets.size();
    endfunction

    function void note_size(logic [3:0] code);
      size_code = code;
      loaded    = 0;
    endfunction

    function void note_element(logic signed [15:0] value);
      int unsigned n;
      n = active_side();
      entries[loaded] = {{(imd_pkg::DET_BITS-16){value[15]}}, value};
      loaded++;
      if (loaded >= n * n) begin
        loaded = 0;
        expected_dets.push_back(expand_cofactors(n));
      end
    endfunction

    function logic [imd_pkg::DET_BITS-1:0] expand_cofactors(int unsigned n);
      logic [imd_pkg::DET_BITS-1:0] sub_dets [1 << MAX_SIDE];
      logic [imd_pkg::DET_BITS-1:0] acc;
      logic [imd_pkg::DET_BITS-1:0] term;
      int unsigned                  row;
      bit                           odd;
      sub_dets[0] = 1;
      for (int unsigned cols = 1; cols < (1 << n); cols++) begin
        // minor over this column set sits on the bottom rows, expand its top row
        row = n - $countones(cols);
        acc = '0;
        odd = 1'b0;
        for (int unsigned j = 0; j < n; j++) begin
          if (((cols >> j) & 1) != 0) begin
            term = entries[row*n + j] * sub_dets[cols & ~(32'd1 << j)];
            acc  = odd ? acc - term : acc + term;
            odd  = ~odd;
          end
        end
        sub_dets[cols] = acc;
      end
      return sub_dets[(1 << n) - 1];
    endfunction

    function void check_result(logic [imd_pkg::DET_BITS-1:0] got);
      logic [imd_pkg::DET_BITS-1:0] want;
      if (expected_dets.size() == 0) begin
        $error("determinant: no result expected, actual %0d", $signed(got));
        mismatches++;
      end else begin
        want = expected_dets.pop_front();
        if (got !== want) begin
          $error("determinant: expected %0d, actual %0d", $signed(want), $signed(got));
          mismatches++;
        end
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
// top-level testbench for the integer matrix determinant block
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEM_TARGET  = 1350;
  localparam int QUIET_CYCLES = 16;
  localparam int STALL_LIMIT  = 20000;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
  typedef enum int {EL_ANY, EL_EXTREME, EL_SMALL, EL_SPARSE} elem_style_e;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [3:0]         cfg_wdata_i     = 4'd0;
  logic               in_valid_i      = 1'b0;
  logic signed [15:0] element_value_i = 16'sd0;
  logic               out_stall_i     = 1'b0;
  wire                in_stall_o;
  wire                out_valid_o;
  wire signed [63:0]  determinant_o;

  det_check_pkg::det_scoreboard dets;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          gap_max     = 3;
  int          idle_cycles = 0;
  int unsigned cyc         = 0;
  int          rx_window   = 0;
  rx_mode_e    rx_mode     = RX_OPEN;

  always #5 clk_i = ~clk_i;

  integer_matrix_determinant u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .determinant_o  (determinant_o)
  );

  // receiver back-pressure, mode changes every window
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rx_window == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 3));
      rx_window <= $urandom_range(20, 200);
    end else begin
      rx_window <= rx_window - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 30);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 80);
      default:  out_stall_i <= ((cyc % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) dets.check_result(determinant_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [15:0] pick_element(elem_style_e style);
    case (style)
      EL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          3:       return 16'h0000;
          default: return 16'h0001;
        endcase
      end
      EL_SMALL:  return 16'(int'($urandom_range(0, 6)) - 3);
      EL_SPARSE: return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'h0000;
      default:   return 16'($urandom());
    endcase
  endfunction

  // sender works in bursts with random gaps in between
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_element(input logic signed [15:0] value);
    pace();
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    dets.note_element(value);
    items_sent++;
  endtask

  // hold off until every determinant is back and a partial load is settled
  task automatic settle();
    in_valid_i <= 1'b0;
    while (dets.pending() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_size(input logic [3:0] code);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dets.note_size(code);
  endtask

  initial begin
    int          phase;
    int          r;
    int unsigned cells;
    logic [3:0]  code;
    elem_style_e style;

    dets = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size after reset is one: each element is its own determinant
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'h0000);
    send_element(16'hFFFF);
    settle();
    write_size(4'd0);
    send_element(16'h0001);
    send_element(16'h5A5A);
    settle();
    // abandoned load, then the same size written again restarts it
    write_size(4'd2);
    send_element(16'h0007);
    send_element(16'hFFFB);
    settle();
    write_size(4'd2);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'h7FFF);
    send_element(16'h8000);
    settle();
    write_size(4'd3);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'hFFFF);
    send_element(16'h0001);
    send_element(16'h8000);
    send_element(16'h7FFF);
    send_element(16'h7FFF);
    send_element(16'h0000);
    send_element(16'h8000);
    settle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: code = 4'd8;
        1: code = 4'd1;
        2: code = 4'd15;
        3: code = 4'd0;
        4: code = 4'd9;
        5: code = 4'd7;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 55) code = 4'($urandom_range(1, 4));
          else if (r < 80) code = 4'($urandom_range(5, 7));
          else if (r < 90) code = 4'd8;
          else if (r < 95) code = 4'd0;
          else code = 4'($urandom_range(9, 15));
        end
      endcase
      write_size(code);
      cells   = dets.active_side() * dets.active_side();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat ((cells >= 25) ? $urandom_range(1, 2) : $urandom_range(1, 5)) begin
        style = elem_style_e'($urandom_range(0, 3));
        repeat (cells) send_element(pick_element(style));
      end
      // sometimes leave a matrix half loaded before the next size write
      if (cells > 1 && $urandom_range(0, 99) < 40)
        repeat ($urandom_range(1, cells - 1)) send_element(pick_element(EL_ANY));
      settle();
      phase++;
    end

    repeat (40) @(posedge clk_i);
    if (dets.mismatches == 0 && dets.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
